// File: design/varint_zigzag_codec_defines.svh
// assertion macros shared by the varint codec modules
`ifndef VARINT_ZIGZAG_CODEC_DEFINES_SVH
`define VARINT_ZIGZAG_CODEC_DEFINES_SVH

`ifndef SYNTHESIS

// checked only while out of reset
`define VZC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every edge, reset included
`define VZC_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`else

`define VZC_ASSERT(label, prop, msg)
`define VZC_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

// File: design/vzc_pkg.sv
// types and constants of the varint zigzag codec
`timescale 1ns / 1ps
`default_nettype none

package vzc_pkg;

   localparam logic OP_ENCODE = 1'b0;
   localparam logic OP_DECODE = 1'b1;

   localparam logic KIND_BYTE  = 1'b0;
   localparam logic KIND_VALUE = 1'b1;

   localparam logic REG_WIDE_MODE = 1'b0;
   localparam logic REG_ZIGZAG    = 1'b1;

   localparam logic [7:0] CONT_BIT      = 8'h80;
   localparam logic [3:0] ENC_MAX_CONT  = 4'd9;
   localparam logic [3:0] LIMIT_NARROW  = 4'd5;
   localparam logic [3:0] LIMIT_WIDE    = 4'd10;
   localparam logic [5:0] GROUP_BITS    = 6'd7;

   typedef struct packed {
      logic        op;
      logic [63:0] value_in;
      logic [7:0]  byte_in;
   } req_beat_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  byte_out;
      logic        last;
      logic [63:0] value_out;
   } rsp_beat_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_ENC,
      SEQ_DEC_OUT
   } seq_state_type;

   // sequencer to datapath
   typedef struct packed {
      logic accept;
      logic enc_load;
      logic enc_emit;
      logic enc_last;
      logic dec_take;
      logic dec_emit;
      logic shift_right;
   } seq_ctrl_type;

   // datapath to sequencer
   typedef struct packed {
      logic work_big;
      logic dec_end;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

// File: design/vzc_shift_unit.sv
// shared 64-bit shifter used for encode group stepping and decode group placement
`timescale 1ns / 1ps
`default_nettype none

module vzc_shift_unit
   import vzc_pkg::*;
(
   input  wire logic [63:0] operand,
   input  wire logic [5:0]  amount,
   input  wire logic        shift_right,
   output logic [63:0]      result
);

   always_comb begin
      if (shift_right) begin
         result = operand >> amount;
      end else begin
         result = operand << amount;
      end
   end

endmodule

`default_nettype wire

// File: design/vzc_seq.sv
// sequencer: input accept, encode byte stepping and decode value emission
`timescale 1ns / 1ps
`default_nettype none
`include "varint_zigzag_codec_defines.svh"

module vzc_seq
   import vzc_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   input  wire logic          req_op,
   input  wire dp_status_type status,
   output logic               req_stall,
   output seq_ctrl_type       ctrl
);

   seq_state_type state_ff, state_in;
   logic [3:0]    count_ff, count_in;
   logic          more;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      ctrl      = '0;
      req_stall = 1'b1;
      // a byte carries the continuation bit while groups remain
      more      = status.work_big && (count_ff < ENC_MAX_CONT);
      unique case (state_ff)
         SEQ_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               ctrl.accept = 1'b1;
               if (req_op == OP_ENCODE) begin
                  ctrl.enc_load = 1'b1;
                  count_in      = '0;
                  state_in      = SEQ_ENC;
               end else begin
                  ctrl.dec_take = 1'b1;
                  if (status.dec_end) begin
                     state_in = SEQ_DEC_OUT;
                  end
               end
            end
         end
         SEQ_ENC: begin
            ctrl.shift_right = 1'b1;
            if (status.out_free) begin
               ctrl.enc_emit = 1'b1;
               ctrl.enc_last = !more;
               count_in      = 4'(count_ff + 4'd1);
               if (!more) begin
                  state_in = SEQ_IDLE;
               end
            end
         end
         SEQ_DEC_OUT: begin
            if (status.out_free) begin
               ctrl.dec_emit = 1'b1;
               state_in      = SEQ_IDLE;
            end
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   `VZC_ASSERT(a_enc_count_bound, (state_ff == SEQ_ENC) |-> (count_ff <= ENC_MAX_CONT),
      "encode ran past ten bytes")
   `VZC_ASSERT(a_last_returns_idle, (ctrl.enc_emit && ctrl.enc_last) |=> (state_ff == SEQ_IDLE),
      "sequencer did not return to idle after the last byte")

endmodule

`default_nettype wire

// File: design/varint_zigzag_codec.sv
// Base-128 varint codec with optional zigzag mapping, 32-bit or 64-bit mode.
// An encode beat (op 0) is taken, then gives one byte per cycle while rsp_stall is low,
// from a shift register stepped by the shared shifter: n bytes, n from 1 to 5 in 32-bit
// mode and 1 to 10 in 64-bit mode, the last byte flagged by last. A decode beat (op 1)
// places one byte into the accumulator; a byte that ends the value moves the sequencer
// to SEQ_DEC_OUT, which emits the value (zigzag undone when enabled). The block takes no
// new beat until the current one is finished, and rsp_stall stretches each emission.
// The user must write registers over the csr port only while the block is idle; the
// block does not enforce it. Index 0: wide_mode (reset 1), 1: zigzag_enable (reset 0).
`timescale 1ns / 1ps
`default_nettype none
`include "varint_zigzag_codec_defines.svh"

module varint_zigzag_codec
   import vzc_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_beat_type req_beat,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_beat_type      rsp_beat,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic         csr_index,
   input  wire logic         csr_wdata
);

   logic          wide_mode_ff, wide_mode_in;
   logic          zigzag_ff, zigzag_in;
   logic [63:0]   acc_ff, acc_in;
   logic [3:0]    gc_ff, gc_in;
   logic [63:0]   work_ff, work_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_beat_type  rsp_beat_ff, rsp_beat_in;

   seq_ctrl_type  ctrl;
   dp_status_type status;

   logic [63:0]   mode_mask;
   logic [63:0]   enc_value;
   logic [63:0]   enc_mapped;
   logic [31:0]   zz_enc32;
   logic [6:0]    dec_shift;
   logic          dec_in_range;
   logic [3:0]    gc_next;
   logic [3:0]    dec_limit;
   logic [63:0]   shift_operand;
   logic [5:0]    shift_amount;
   logic [63:0]   shift_result;
   logic [63:0]   dec_value;
   logic [31:0]   zz_dec32;

   assign csr_ready = 1'b1;

   always_comb begin
      wide_mode_in = wide_mode_ff;
      zigzag_in    = zigzag_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_WIDE_MODE: wide_mode_in = csr_wdata;
            REG_ZIGZAG:    zigzag_in    = csr_wdata;
            default:       ;
         endcase
      end
   end

   assign mode_mask = wide_mode_ff ? {64{1'b1}} : {32'd0, {32{1'b1}}};

   // encode operand, with zigzag applied when enabled
   assign enc_value = req_beat.value_in & mode_mask;
   assign zz_enc32  = {enc_value[30:0], 1'b0} ^ {32{enc_value[31]}};
   always_comb begin
      if (!zigzag_ff) begin
         enc_mapped = enc_value;
      end else if (wide_mode_ff) begin
         enc_mapped = {enc_value[62:0], 1'b0} ^ {64{enc_value[63]}};
      end else begin
         enc_mapped = {32'd0, zz_enc32};
      end
   end

   // decode group position is 7 * group count
   assign dec_shift    = {gc_ff, 3'b000} - {3'b000, gc_ff};
   assign dec_in_range = wide_mode_ff ? !dec_shift[6] : (dec_shift[6:5] == 2'b00);
   assign gc_next      = 4'(gc_ff + 4'd1);
   assign dec_limit    = wide_mode_ff ? LIMIT_WIDE : LIMIT_NARROW;

   assign shift_operand = ctrl.shift_right ? work_ff : {57'd0, req_beat.byte_in[6:0]};
   assign shift_amount  = ctrl.shift_right ? GROUP_BITS : dec_shift[5:0];

   vzc_shift_unit u_shift (
      .operand     (shift_operand),
      .amount      (shift_amount),
      .shift_right (ctrl.shift_right),
      .result      (shift_result)
   );

   assign status.work_big = |work_ff[63:7];
   assign status.dec_end  = !req_beat.byte_in[7] || (gc_next >= dec_limit) || (gc_next == 4'd0);
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   vzc_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_beat.op),
      .status    (status),
      .req_stall (req_stall),
      .ctrl      (ctrl)
   );

   // value leaving the decoder
   assign zz_dec32 = (acc_ff[31:0] >> 1) ^ {32{acc_ff[0]}};
   always_comb begin
      if (!zigzag_ff) begin
         dec_value = acc_ff & mode_mask;
      end else if (wide_mode_ff) begin
         dec_value = (acc_ff >> 1) ^ {64{acc_ff[0]}};
      end else begin
         dec_value = {{32{zz_dec32[31]}}, zz_dec32};
      end
   end

   always_comb begin
      acc_in       = acc_ff;
      gc_in        = gc_ff;
      work_in      = work_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_beat_in  = rsp_beat_ff;
      if (ctrl.enc_load) begin
         work_in = enc_mapped;
      end
      if (ctrl.dec_take) begin
         acc_in = (acc_ff | (dec_in_range ? shift_result : 64'd0)) & mode_mask;
         gc_in  = gc_next;
      end
      if (ctrl.enc_emit) begin
         work_in               = shift_result;
         rsp_valid_in          = 1'b1;
         rsp_beat_in.kind      = KIND_BYTE;
         rsp_beat_in.byte_out  = ctrl.enc_last ? work_ff[7:0] : (CONT_BIT | {1'b0, work_ff[6:0]});
         rsp_beat_in.last      = ctrl.enc_last;
         rsp_beat_in.value_out = '0;
      end
      if (ctrl.dec_emit) begin
         acc_in                = '0;
         gc_in                 = '0;
         rsp_valid_in          = 1'b1;
         rsp_beat_in.kind      = KIND_VALUE;
         rsp_beat_in.byte_out  = '0;
         rsp_beat_in.last      = 1'b1;
         rsp_beat_in.value_out = dec_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wide_mode_ff <= 1'b1;
         zigzag_ff    <= 1'b0;
         acc_ff       <= '0;
         gc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wide_mode_ff <= wide_mode_in;
         zigzag_ff    <= zigzag_in;
         acc_ff       <= acc_in;
         gc_ff        <= gc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff     <= work_in;
      rsp_beat_ff <= rsp_beat_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat  = rsp_beat_ff;

   `VZC_ASSERT(a_emit_has_room, (ctrl.enc_emit || ctrl.dec_emit) |-> status.out_free,
      "result loaded over a held beat")
   `VZC_ASSERT(a_dec_emit_clears, ctrl.dec_emit |=> (gc_ff == 4'd0 && acc_ff == 64'd0),
      "decoder state not cleared after a value")
   `VZC_ASSERT(a_accept_handshake, ctrl.accept |-> (req_valid && !req_stall),
      "beat taken without a handshake")
   `VZC_ASSERT_ALWAYS(a_reset_quiet, reset |=> (!rsp_valid_ff && gc_ff == 4'd0),
      "output or decoder busy after reset")

endmodule

`default_nettype wire
